FILE: sv/fcte_pkg.sv
package fcte_pkg;

  localparam int SLOTS = 64;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int MS_PER_S = 1000;
  localparam int FLAG_FIN_BIT = 0;
  localparam int FLAG_RST_BIT = 2;

  localparam logic [1:0] REG_ACTIVE = 2'd0;
  localparam logic [1:0] REG_INACTIVE = 2'd1;
  localparam logic [1:0] REG_LIMIT = 2'd2;

  typedef struct packed {
    logic [31:0] src;
    logic [31:0] dst;
    logic [31:0] ports;
    logic [7:0]  proto;
    logic [7:0]  tos;
    logic [7:0]  flags;
    logic [31:0] pkts;
    logic [31:0] octs;
    logic [31:0] first;
    logic [31:0] last;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SWEEP,
    S_TAIL,
    S_PICK,
    S_FIX,
    S_END
  } state_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic pick;
    logic fix;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic is_flush;
    logic need_fix;
  } sts_t;

endpackage

FILE: sv/fcte_ram.sv
module fcte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/fcte_ctrl.sv
module fcte_ctrl import fcte_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    busy = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = S_SWEEP;
        end
      end
      S_SWEEP: begin
        cmd.issue = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_TAIL;
        end
      end
      S_TAIL: begin
        // last slot of the sweep is checked here
        state_nxt = sts.is_flush ? S_END : S_PICK;
      end
      S_PICK: begin
        cmd.pick = 1'b1;
        state_nxt = sts.need_fix ? S_FIX : S_END;
      end
      S_FIX: begin
        cmd.fix = 1'b1;
        state_nxt = S_END;
      end
      S_END: begin
        cmd.finish = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

FILE: sv/fcte_dp.sv
module fcte_dp import fcte_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_mode,
  input  logic [31:0] in_stamp_ms,
  input  logic [31:0] in_src_addr,
  input  logic [31:0] in_dst_addr,
  input  logic [15:0] in_src_port,
  input  logic [15:0] in_dst_port,
  input  logic [7:0]  in_protocol,
  input  logic [7:0]  in_tos,
  input  logic [7:0]  in_tcp_flags,
  input  logic [15:0] in_ip_length,
  output logic        out_strobe,
  output logic [31:0] out_src_addr,
  output logic [31:0] out_dst_addr,
  output logic [31:0] out_port_pair,
  output logic [23:0] out_proto_tos_flags,
  output logic [31:0] out_packets,
  output logic [31:0] out_octets,
  output logic [31:0] out_first_ms,
  output logic [31:0] out_last_ms,
  output logic [31:0] out_uptime_ms,
  output logic [31:0] out_sequence_res,
  output logic        out_last_of_run
);

  // configuration
  logic [15:0] act_s_r, inact_s_r;
  logic [6:0]  limit_r;

  // item
  logic        mode_r;
  logic [31:0] key_src_r, key_dst_r, key_ports_r;
  logic [7:0]  key_proto_r, tos_r, flags_r;
  logic [15:0] len_r;
  logic [31:0] uptime_r, act_ms_r, inact_ms_r;

  logic        origin_seen_r;
  logic [31:0] origin_r, last_up_r, seq_r, seq_nxt;
  logic [SLOTS-1:0] valid_r, valid_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  logic [SLOT_W-1:0] scan_r, chk_slot_r;
  logic              chk_vld_r;
  logic              match_vld_r, old_vld_r, free_vld_r;
  logic [SLOT_W-1:0] match_slot_r, old_slot_r, free_slot_r;
  logic [31:0]       old_first_r;
  logic              fix_match_r, fix_evict_r;

  logic        pend_vld_r;
  rec_t        pend_rec_r;
  logic [31:0] pend_up_r, pend_seq_r;

  logic        ram_we;
  logic [SLOT_W-1:0] ram_waddr, ram_raddr, evict_dst;
  rec_t        ram_wrec, rd_rec, new_rec, upd_rec, exp_rec;
  logic [REC_W-1:0] ram_rdata;

  logic [25:0] act_prod, inact_prod;
  logic [31:0] stamp_up;
  logic [CNT_W-1:0] eff_limit;
  logic chk_live, expired, key_hit, evict_now, exp_go, emit, fin_rst;

  fcte_ram #(.WIDTH(REC_W), .DEPTH(SLOTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wrec),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    rd_rec = rec_t'(ram_rdata);
    act_prod = 26'(act_s_r) * 26'(MS_PER_S);
    inact_prod = 26'(inact_s_r) * 26'(MS_PER_S);
    stamp_up = origin_seen_r ? (in_stamp_ms - origin_r) : 32'd0;
    if (limit_r == 7'd0) begin
      eff_limit = CNT_W'(1);
    end else if (limit_r > 7'(SLOTS)) begin
      eff_limit = CNT_W'(SLOTS);
    end else begin
      eff_limit = CNT_W'(limit_r);
    end

    chk_live = chk_vld_r && valid_r[chk_slot_r];
    expired = mode_r || ((uptime_r - rd_rec.first) > act_ms_r)
                     || ((uptime_r - rd_rec.last) > inact_ms_r);
    key_hit = (rd_rec.src == key_src_r) && (rd_rec.dst == key_dst_r)
           && (rd_rec.ports == key_ports_r) && (rd_rec.proto == key_proto_r);
    evict_now = (count_r >= eff_limit) && old_vld_r;
    fin_rst = flags_r[FLAG_FIN_BIT] || flags_r[FLAG_RST_BIT];

    new_rec.src = key_src_r;
    new_rec.dst = key_dst_r;
    new_rec.ports = key_ports_r;
    new_rec.proto = key_proto_r;
    new_rec.tos = tos_r;
    new_rec.flags = flags_r;
    new_rec.pkts = 32'd1;
    new_rec.octs = 32'(len_r);
    new_rec.first = uptime_r;
    new_rec.last = uptime_r;

    upd_rec = rd_rec;
    upd_rec.last = uptime_r;
    upd_rec.octs = rd_rec.octs + 32'(len_r);
    upd_rec.pkts = rd_rec.pkts + 32'd1;
    upd_rec.flags = rd_rec.flags | flags_r;

    // lowest free slot once the evicted one is gone
    evict_dst = (free_vld_r && (free_slot_r < old_slot_r)) ? free_slot_r : old_slot_r;

    sts.scan_last = (scan_r == SLOT_W'(SLOTS - 1));
    sts.is_flush = mode_r;
    sts.need_fix = match_vld_r || evict_now;

    ram_raddr = scan_r;
    ram_we = 1'b0;
    ram_waddr = free_slot_r;
    ram_wrec = new_rec;
    valid_nxt = valid_r;
    count_nxt = count_r;
    exp_go = 1'b0;
    exp_rec = rd_rec;

    if (chk_live && expired) begin
      exp_go = 1'b1;
      valid_nxt[chk_slot_r] = 1'b0;
      count_nxt = count_r - CNT_W'(1);
    end

    if (cmd.pick) begin
      if (match_vld_r) begin
        ram_raddr = match_slot_r;
      end else if (evict_now) begin
        ram_raddr = old_slot_r;
      end else if (free_vld_r) begin
        ram_we = 1'b1;
        valid_nxt[free_slot_r] = 1'b1;
        count_nxt = count_r + CNT_W'(1);
      end
    end

    if (cmd.fix) begin
      if (fix_match_r) begin
        ram_we = 1'b1;
        ram_waddr = match_slot_r;
        ram_wrec = upd_rec;
        if (fin_rst) begin
          exp_go = 1'b1;
          exp_rec = upd_rec;
          valid_nxt[match_slot_r] = 1'b0;
          count_nxt = count_r - CNT_W'(1);
        end
      end else if (fix_evict_r) begin
        exp_go = 1'b1;
        valid_nxt[old_slot_r] = 1'b0;
        ram_we = 1'b1;
        ram_waddr = evict_dst;
        valid_nxt[evict_dst] = 1'b1;
      end
    end

    seq_nxt = exp_go ? seq_r + 32'd1 : seq_r;
    emit = pend_vld_r && (exp_go || cmd.finish);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_s_r <= 16'd60;
      inact_s_r <= 16'd10;
      limit_r <= 7'(SLOTS);
      origin_seen_r <= 1'b0;
      origin_r <= '0;
      last_up_r <= '0;
      seq_r <= '0;
      valid_r <= '0;
      count_r <= '0;
      chk_vld_r <= 1'b0;
      pend_vld_r <= 1'b0;
      out_strobe <= 1'b0;
      scan_r <= '0;
      match_vld_r <= 1'b0;
      old_vld_r <= 1'b0;
      free_vld_r <= 1'b0;
      fix_match_r <= 1'b0;
      fix_evict_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ACTIVE:   act_s_r <= cfg_data;
          REG_INACTIVE: inact_s_r <= cfg_data;
          REG_LIMIT:    limit_r <= cfg_data[6:0];
          default: ;
        endcase
      end
      valid_r <= valid_nxt;
      count_r <= count_nxt;
      seq_r <= seq_nxt;
      chk_vld_r <= cmd.issue;
      out_strobe <= emit;
      if (exp_go) begin
        pend_vld_r <= 1'b1;
      end else if (cmd.finish) begin
        pend_vld_r <= 1'b0;
      end
      if (cmd.issue) begin
        scan_r <= scan_r + SLOT_W'(1);
      end
      if (cmd.load) begin
        scan_r <= '0;
        match_vld_r <= 1'b0;
        old_vld_r <= 1'b0;
        free_vld_r <= 1'b0;
        if (!in_mode) begin
          last_up_r <= stamp_up;
          if (!origin_seen_r) begin
            origin_seen_r <= 1'b1;
            origin_r <= in_stamp_ms;
          end
        end
      end
      if (chk_vld_r) begin
        if (chk_live && !expired) begin
          if (!match_vld_r && key_hit) begin
            match_vld_r <= 1'b1;
          end
          if (!old_vld_r || (rd_rec.first < old_first_r)) begin
            old_vld_r <= 1'b1;
          end
        end else if (!free_vld_r) begin
          free_vld_r <= 1'b1;
        end
      end
      if (cmd.pick) begin
        fix_match_r <= match_vld_r;
        fix_evict_r <= !match_vld_r && evict_now;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      key_src_r <= in_src_addr;
      key_dst_r <= in_dst_addr;
      key_ports_r <= {in_src_port, in_dst_port};
      key_proto_r <= in_protocol;
      tos_r <= in_tos;
      flags_r <= in_tcp_flags;
      len_r <= in_ip_length;
      uptime_r <= in_mode ? last_up_r : stamp_up;
      act_ms_r <= 32'(act_prod);
      inact_ms_r <= 32'(inact_prod);
    end
    if (chk_vld_r && chk_live && !expired) begin
      if (!match_vld_r && key_hit) begin
        match_slot_r <= chk_slot_r;
      end
      if (!old_vld_r || (rd_rec.first < old_first_r)) begin
        old_slot_r <= chk_slot_r;
        old_first_r <= rd_rec.first;
      end
    end else if (chk_vld_r && !free_vld_r) begin
      free_slot_r <= chk_slot_r;
    end
    chk_slot_r <= scan_r;
    // a beat waits in pend until the next one or the end of the item shows it is last
    if (exp_go) begin
      pend_rec_r <= exp_rec;
      pend_up_r <= uptime_r;
      pend_seq_r <= seq_r;
    end
    if (emit) begin
      out_src_addr <= pend_rec_r.src;
      out_dst_addr <= pend_rec_r.dst;
      out_port_pair <= pend_rec_r.ports;
      out_proto_tos_flags <= {pend_rec_r.proto, pend_rec_r.tos, pend_rec_r.flags};
      out_packets <= pend_rec_r.pkts;
      out_octets <= pend_rec_r.octs;
      out_first_ms <= pend_rec_r.first;
      out_last_ms <= pend_rec_r.last;
      out_uptime_ms <= pend_up_r;
      out_sequence_res <= pend_seq_r;
      out_last_of_run <= cmd.finish;
    end
  end

endmodule

FILE: sv/flow_cache_timeout_export.sv
// start is taken only when idle, so one item is handled at a time; the slot sweep reads
// one slot a cycle from the record ram, then a packet (not a flush) updates its matched slot,
// or evicts the oldest flow for the new one when full, or writes the new flow into a free slot
// at most one export beat per cycle; the last beat of an item comes in the first cycle after busy falls
// the receiver cannot stall; out_strobe marks each beat for one cycle
// reset (synchronous, rst_n low) empties the cache and restores the default timeouts and limit
module flow_cache_timeout_export import fcte_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_mode,
  input  logic [31:0] in_stamp_ms,
  input  logic [31:0] in_src_addr,
  input  logic [31:0] in_dst_addr,
  input  logic [15:0] in_src_port,
  input  logic [15:0] in_dst_port,
  input  logic [7:0]  in_protocol,
  input  logic [7:0]  in_tos,
  input  logic [7:0]  in_tcp_flags,
  input  logic [15:0] in_ip_length,
  output logic        out_strobe,
  output logic [31:0] out_src_addr,
  output logic [31:0] out_dst_addr,
  output logic [31:0] out_port_pair,
  output logic [23:0] out_proto_tos_flags,
  output logic [31:0] out_packets,
  output logic [31:0] out_octets,
  output logic [31:0] out_first_ms,
  output logic [31:0] out_last_ms,
  output logic [31:0] out_uptime_ms,
  output logic [31:0] out_sequence_res,
  output logic        out_last_of_run
);

  cmd_t cmd;
  sts_t sts;

  fcte_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  fcte_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_mode             (in_mode),
    .in_stamp_ms         (in_stamp_ms),
    .in_src_addr         (in_src_addr),
    .in_dst_addr         (in_dst_addr),
    .in_src_port         (in_src_port),
    .in_dst_port         (in_dst_port),
    .in_protocol         (in_protocol),
    .in_tos              (in_tos),
    .in_tcp_flags        (in_tcp_flags),
    .in_ip_length        (in_ip_length),
    .out_strobe          (out_strobe),
    .out_src_addr        (out_src_addr),
    .out_dst_addr        (out_dst_addr),
    .out_port_pair       (out_port_pair),
    .out_proto_tos_flags (out_proto_tos_flags),
    .out_packets         (out_packets),
    .out_octets          (out_octets),
    .out_first_ms        (out_first_ms),
    .out_last_ms         (out_last_ms),
    .out_uptime_ms       (out_uptime_ms),
    .out_sequence_res    (out_sequence_res),
    .out_last_of_run     (out_last_of_run)
  );

endmodule
